### hdl/absolute_humidity_from_temp_rh_core_assert.svh
// Assertion macros for the absolute humidity core.
// Depends on nothing; included by the top level only.
`ifndef ABSOLUTE_HUMIDITY_FROM_TEMP_RH_CORE_ASSERT_SVH
`define ABSOLUTE_HUMIDITY_FROM_TEMP_RH_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AHUM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ahum: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define AHUM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ahum: next-cycle check failed");

`endif

### hdl/ahum_pkg.sv
// Shared types, constants and coefficient tables of the absolute humidity core.
// Depends on nothing.
package ahum_pkg;

  // Input transaction payload.
  typedef struct packed {
    logic signed [14:0] temperature_centi_c;
    logic [13:0]        relative_humidity_centi_pct;
  } ahum_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [15:0] saturation_pressure_pa;
    logic [18:0] absolute_humidity_mg_m3;
    logic        over_ice;
  } ahum_out_t;

  // Fixed-point formats of the exponent fraction and of the 10^f value (Q30).
  localparam int FRAC_W = 16;
  localparam int EXP_W  = 34;

  // Input limits.
  localparam logic signed [14:0] T_MIN  = -15'sd4000;
  localparam logic signed [14:0] T_MAX  = 15'sd8500;
  localparam logic [13:0]        RH_MAX = 14'd10000;

  // Magnus coefficients: k2 in thousandths, k3 in hundredths of a degree.
  localparam logic [14:0] K2_WATER = 15'd17368;
  localparam logic [14:0] K2_ICE   = 15'd17966;
  localparam logic [14:0] K3_WATER = 15'd23888;
  localparam logic [14:0] K3_ICE   = 15'd24715;

  // Misc scale factors.
  localparam logic [15:0] T_KELVIN_CENTI = 16'd27315;
  localparam logic [9:0]  DEN1_SCALE     = 10'd1000;
  localparam logic [8:0]  DEN1_HALF      = 9'd500;
  localparam logic [15:0] GAS_CONST      = 16'd46151;
  localparam logic [19:0] X_OFFSET       = 20'd262144;
  localparam logic [3:0]  IP_MAX         = 4'd8;
  localparam logic [13:0] ES_DIV         = 14'd15625;
  localparam logic [41:0] ES_HALF        = 42'd15625 << 27;
  localparam logic [15:0] PA_MAX         = 16'hFFFF;
  localparam logic [18:0] AH_MAX         = 19'h7FFFF;

  // ceil(2^63 / 15625): multiplying by it and dropping 63 bits divides exactly by
  // 15625 for any dividend below 2^49.
  localparam logic [49:0] ES_RECIP       = 50'd590295810358706;

  // 61121 * 10^ip, the pressure scale for each integer exponent part.
  function automatic logic [42:0] es_scale(input logic [3:0] ip);
    logic [42:0] c;
    case (ip)
      4'd0:    c = 43'd61121;
      4'd1:    c = 43'd611210;
      4'd2:    c = 43'd6112100;
      4'd3:    c = 43'd61121000;
      4'd4:    c = 43'd611210000;
      4'd5:    c = 43'd6112100000;
      4'd6:    c = 43'd61121000000;
      4'd7:    c = 43'd611210000000;
      4'd8:    c = 43'd6112100000000;
      default: c = 43'd0;
    endcase
    return c;
  endfunction

endpackage

### hdl/ahum_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; used by the top level of the absolute humidity core.
module ahum_div_pipe #(
  parameter int DW = 45,
  parameter int VW = 25,
  parameter int QW = 20,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [QW-1:0] quot_o,
  output logic [SW-1:0] side_o
);

  // The caller guarantees dividend < divisor * 2^QW and DW - QW <= VW.
  logic          vld_q [QW];
  logic [VW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [VW-1:0] dvs_q [QW];
  logic [SW-1:0] sd_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vld_in;
    logic [VW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [VW-1:0] dvs_in;
    logic [SW-1:0] sd_in;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    // The first stage takes the upper dividend bits as partial remainder.
    if (k == 0) begin : g_first
      assign vld_in = vld_i;
      assign rem_in = VW'(dividend_i >> QW);
      assign low_in = dividend_i[QW-1:0];
      assign quo_in = '0;
      assign dvs_in = divisor_i;
      assign sd_in  = side_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign sd_in  = sd_q[k-1];
    end

    // Shift in the next dividend bit and try a subtraction.
    always_comb begin
      trial = {rem_in, low_in[QW-1]};
      diff  = trial - {1'b0, dvs_in};
      ge    = (trial >= {1'b0, dvs_in});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_in) begin
        rem_q[k] <= ge ? diff[VW-1:0] : trial[VW-1:0];
        low_q[k] <= low_in << 1;
        quo_q[k] <= {quo_in[QW-2:0], ge};
        dvs_q[k] <= dvs_in;
        sd_q[k]  <= sd_in;
      end
    end
  end

  assign vld_o  = vld_q[QW-1];
  assign quot_o = quo_q[QW-1];
  assign side_o = sd_q[QW-1];

endmodule

### hdl/ahum_exp10.sv
// 10^f for a 16-bit fraction f: table lookup and linear interpolation, two stages.
// Depends on ahum_pkg for the fraction and result formats.
module ahum_exp10 #(
  parameter int EXP_TABLE_BITS = 6,
  parameter int SW             = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [ahum_pkg::FRAC_W-1:0] frac_i,
  input  logic [SW-1:0]              side_i,
  output logic                       vld_o,
  output logic [ahum_pkg::EXP_W-1:0] pow_o,
  output logic [SW-1:0]              side_o
);

  localparam int EW       = ahum_pkg::EXP_W;
  localparam int SH       = ahum_pkg::FRAC_W - EXP_TABLE_BITS;
  localparam int ROM_SIZE = (1 << EXP_TABLE_BITS) + 1;
  localparam int IW       = EXP_TABLE_BITS + 1;
  localparam int PW       = EW + SH + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (SH - 1);

  typedef logic [EW-1:0] rom_t [ROM_SIZE];

  // Floor integer square root, used only while the table is built.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry i holds 10^(i / 2^EXP_TABLE_BITS) in Q30, built by repeated ratio steps.
  function automatic rom_t build_rom();
    rom_t         rom;
    logic [63:0]  ratio;
    logic [127:0] prod;
    ratio = 64'd10 << 30;
    for (int k = 0; k < EXP_TABLE_BITS; k++) begin
      ratio = isqrt64(ratio << 30);
    end
    rom[0] = EW'(64'd1 << 30);
    for (int k = 1; k < ROM_SIZE; k++) begin
      prod   = 128'(rom[k-1]) * 128'(ratio) + (128'd1 << 29);
      rom[k] = EW'(prod >> 30);
    end
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  logic          s1_vld_q, s2_vld_q;
  logic [IW-1:0] idx;
  logic [EW-1:0] e0_q, e1_q;
  logic [SH-1:0] rem_q;
  logic [SW-1:0] s1_side_q, s2_side_q;
  logic [PW-1:0] interp;
  logic [EW-1:0] pow_d, pow_q;

  // Stage 1: fetch the two neighboring table entries.
  assign idx = IW'(frac_i >> SH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      e0_q      <= EXP_ROM[idx];
      e1_q      <= EXP_ROM[idx + IW'(1)];
      rem_q     <= frac_i[SH-1:0];
      s1_side_q <= side_i;
    end
  end

  // Stage 2: interpolate on the low fraction bits, rounding half up.
  always_comb begin
    interp = PW'(e1_q - e0_q) * PW'(rem_q) + HALF;
    pow_d  = e0_q + EW'(interp >> SH);
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      pow_q     <= pow_d;
      s2_side_q <= s1_side_q;
    end
  end

  assign vld_o  = s2_vld_q;
  assign pow_o  = pow_q;
  assign side_o = s2_side_q;

endmodule

### hdl/absolute_humidity_from_temp_rh_core.sv
// Top level of the absolute humidity core: clamping, exponent, pressure, humidity.
// Depends on ahum_pkg, ahum_div_pipe, ahum_exp10 and the assertion macro header.
//
//   channel  | ports                       | handshake
//   ---------+-----------------------------+-------------------------------
//   input    | start, busy, data_i         | taken when start && !busy
//   result   | done_o, result_o            | one-cycle strobe, no backpressure
//
// One transaction enters per cycle; busy stays low, nothing in the pipe stalls.
// Most of the pipeline is the two restoring dividers, one quotient bit per stage
// (exponent 20 stages, humidity 19 stages); the pressure division by 15625 is
// a three-stage reciprocal multiply.
// Reset clears the valid bits of every stage; the data path is not reset.
// Each transaction gives exactly one result.
`include "absolute_humidity_from_temp_rh_core_assert.svh"

module absolute_humidity_from_temp_rh_core #(
  parameter int EXP_TABLE_BITS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ahum_pkg::ahum_in_t  data_i,
  output logic                done_o,
  output ahum_pkg::ahum_out_t result_o
);

  localparam int DIV1_QW = 20;
  localparam int DIV3_QW = 19;
  localparam int LATENCY = 3 + DIV1_QW + 1 + 2 + 2 + 3 + 3 + DIV3_QW + 1;

  typedef struct packed {
    logic        ice;
    logic [13:0] rh;
    logic [30:0] e_den;
  } side_t;

  typedef struct packed {
    logic        ice;
    logic [13:0] rh;
    logic [30:0] e_den;
    logic [3:0]  ip;
  } side_x_t;

  typedef struct packed {
    logic        ice;
    logic [30:0] e_den;
    logic [15:0] pa;
  } side_j_t;

  typedef struct packed {
    logic [15:0] pa;
    logic        ice;
    logic        sat;
  } side_k_t;

  // The pipeline never stalls, so a transaction can be accepted in every cycle that start is high.
  assign busy = 1'b0;

  // Stage A: clamp the inputs.
  logic                a_vld_q;
  logic signed [14:0]  t_in, a_t_d, a_t_q;
  logic [13:0]         rh_in, a_rh_d, a_rh_q;

  always_comb begin
    t_in  = data_i.temperature_centi_c;
    rh_in = data_i.relative_humidity_centi_pct;
    if (t_in < ahum_pkg::T_MIN) begin
      a_t_d = ahum_pkg::T_MIN;
    end else if (t_in > ahum_pkg::T_MAX) begin
      a_t_d = ahum_pkg::T_MAX;
    end else begin
      a_t_d = t_in;
    end
    a_rh_d = (rh_in > ahum_pkg::RH_MAX) ? ahum_pkg::RH_MAX : rh_in;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      a_t_q  <= a_t_d;
      a_rh_q <= a_rh_d;
    end
  end

  // Stage B: pick the coefficients, form k2*|T|, k3+T and T in kelvin.
  logic        b_vld_q, b_ice_q;
  logic [13:0] b_rh_q;
  logic [14:0] k2m, k3c, t_bits, t_neg;
  logic [13:0] tabs;
  logic [15:0] k3t, tk;
  logic [27:0] b_kt_d, b_kt_q;
  logic [14:0] b_k3t_q;
  logic [15:0] b_tk_q;

  always_comb begin
    t_bits = a_t_q;
    t_neg  = 15'(~t_bits + 15'd1);
    k2m    = t_bits[14] ? ahum_pkg::K2_ICE : ahum_pkg::K2_WATER;
    k3c    = t_bits[14] ? ahum_pkg::K3_ICE : ahum_pkg::K3_WATER;
    tabs   = 14'(t_bits[14] ? t_neg : t_bits);
    b_kt_d = 28'(k2m) * 28'(tabs);
    k3t    = {1'b0, k3c} + {t_bits[14], t_bits};
    tk     = ahum_pkg::T_KELVIN_CENTI + {t_bits[14], t_bits};
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_ice_q <= t_bits[14];
      b_rh_q  <= a_rh_q;
      b_kt_q  <= b_kt_d;
      b_k3t_q <= k3t[14:0];
      b_tk_q  <= tk;
    end
  end

  // Stage C: exponent numerator and denominator, gas-law denominator.
  logic        c_vld_q;
  logic [44:0] c_num_q;
  logic [24:0] c_den_q;
  side_t       c_side_q;

  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      c_num_q        <= 45'({b_kt_q, 16'h0000}) +
                        45'(b_k3t_q) * 45'(ahum_pkg::DEN1_HALF);
      c_den_q        <= 25'(b_k3t_q) * 25'(ahum_pkg::DEN1_SCALE);
      c_side_q.ice   <= b_ice_q;
      c_side_q.rh    <= b_rh_q;
      c_side_q.e_den <= 31'(b_tk_q) * 31'(ahum_pkg::GAS_CONST);
    end
  end

  // Exponent magnitude in Q16.
  logic               q1_vld;
  logic [DIV1_QW-1:0] q1_quot;
  side_t              q1_side;

  ahum_div_pipe #(
    .DW (45),
    .VW (25),
    .QW (DIV1_QW),
    .SW ($bits(side_t))
  ) u_div_exp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (c_vld_q),
    .dividend_i (c_num_q),
    .divisor_i  (c_den_q),
    .side_i     (c_side_q),
    .vld_o      (q1_vld),
    .quot_o     (q1_quot),
    .side_o     (q1_side)
  );

  // Stage D: offset the exponent by four and split it.
  logic        d_vld_q;
  logic [19:0] xoff;
  logic [3:0]  ip_raw;
  logic [15:0] d_frac_q;
  side_x_t     d_side_q;

  always_comb begin
    xoff   = q1_side.ice ? (ahum_pkg::X_OFFSET - q1_quot) : (ahum_pkg::X_OFFSET + q1_quot);
    ip_raw = xoff[19:16];
  end

  always_ff @(posedge clk_i) begin
    if (q1_vld) begin
      d_frac_q       <= xoff[15:0];
      d_side_q.ice   <= q1_side.ice;
      d_side_q.rh    <= q1_side.rh;
      d_side_q.e_den <= q1_side.e_den;
      d_side_q.ip    <= (ip_raw > ahum_pkg::IP_MAX) ? ahum_pkg::IP_MAX : ip_raw;
    end
  end

  // 10^fraction in Q30.
  logic                       x_vld;
  logic [ahum_pkg::EXP_W-1:0] x_pow;
  side_x_t                    x_side;

  ahum_exp10 #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS),
    .SW             ($bits(side_x_t))
  ) u_exp10 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d_vld_q),
    .frac_i (d_frac_q),
    .side_i (d_side_q),
    .vld_o  (x_vld),
    .pow_o  (x_pow),
    .side_o (x_side)
  );

  // Stage G: low partial product of 61121 * 10^ip * p.
  logic        g_vld_q;
  logic [42:0] g_c_q;
  logic [16:0] g_phi_q;
  logic [59:0] g_pplo_q;
  side_t       g_side_q;
  logic [42:0] g_c_d;

  assign g_c_d = ahum_pkg::es_scale(x_side.ip);

  always_ff @(posedge clk_i) begin
    if (x_vld) begin
      g_c_q          <= g_c_d;
      g_phi_q        <= x_pow[33:17];
      g_pplo_q       <= 60'(g_c_d) * 60'(x_pow[16:0]);
      g_side_q.ice   <= x_side.ice;
      g_side_q.rh    <= x_side.rh;
      g_side_q.e_den <= x_side.e_den;
    end
  end

  // Stage H: high partial product, rounding offset, drop the power-of-two part.
  logic        h_vld_q;
  logic [76:0] h_full;
  logic [48:0] h_n1_q;
  side_t       h_side_q;

  assign h_full = (77'(60'(g_c_q) * 60'(g_phi_q)) << 17) + 77'(g_pplo_q) +
                  77'(ahum_pkg::ES_HALF);

  always_ff @(posedge clk_i) begin
    if (g_vld_q) begin
      h_n1_q   <= h_full[76:28];
      h_side_q <= g_side_q;
    end
  end

  // Stages R1 to R3: divide by 15625 as (n * ES_RECIP) >> 63, with the product split into
  // four partial products of the 25- and 24-bit halves of n and 25-bit halves of ES_RECIP.
  logic        r1_vld_q, r2_vld_q, r3_vld_q;
  logic [49:0] r1_hh_q, r1_hl_q, r1_lh_q, r1_ll_q;
  side_t       r1_side_q, r2_side_q, r3_side_q;
  logic [49:0] r2_hh_q;
  logic [75:0] r2_low_q;
  logic [98:0] r_full;
  logic [34:0] r3_es8_q;

  always_ff @(posedge clk_i) begin
    if (h_vld_q) begin
      r1_hh_q   <= 50'(h_n1_q[48:24]) * 50'(ahum_pkg::ES_RECIP[49:25]);
      r1_hl_q   <= 50'(h_n1_q[48:24]) * 50'(ahum_pkg::ES_RECIP[24:0]);
      r1_lh_q   <= 50'(h_n1_q[23:0]) * 50'(ahum_pkg::ES_RECIP[49:25]);
      r1_ll_q   <= 50'(h_n1_q[23:0]) * 50'(ahum_pkg::ES_RECIP[24:0]);
      r1_side_q <= h_side_q;
    end
  end

  // Sum the lower partial products.
  always_ff @(posedge clk_i) begin
    if (r1_vld_q) begin
      r2_hh_q   <= r1_hh_q;
      r2_low_q  <= (76'(r1_hl_q) << 24) + (76'(r1_lh_q) << 25) + 76'(r1_ll_q);
      r2_side_q <= r1_side_q;
    end
  end

  // Add the top partial product and keep the quotient bits.
  assign r_full = (99'(r2_hh_q) << 49) + 99'(r2_low_q);

  always_ff @(posedge clk_i) begin
    if (r2_vld_q) begin
      r3_es8_q  <= r_full[97:63];
      r3_side_q <= r2_side_q;
    end
  end

  // Saturation pressure in Pa Q8.
  logic        q2_vld;
  logic [34:0] es8;
  side_t       q2_side;

  assign q2_vld  = r3_vld_q;
  assign es8     = r3_es8_q;
  assign q2_side = r3_side_q;

  // Stage I: pressure output and es8 * RH.
  logic        i_vld_q;
  logic [35:0] pa_sum;
  logic [27:0] pa_int;
  logic [48:0] i_esrh_q;
  side_j_t     i_side_q;

  always_comb begin
    pa_sum = 36'(es8) + 36'd128;
    pa_int = pa_sum[35:8];
  end

  always_ff @(posedge clk_i) begin
    if (q2_vld) begin
      i_esrh_q       <= 49'(es8) * 49'(q2_side.rh);
      i_side_q.ice   <= q2_side.ice;
      i_side_q.e_den <= q2_side.e_den;
      i_side_q.pa    <= (pa_int > 28'(ahum_pkg::PA_MAX)) ? ahum_pkg::PA_MAX : pa_int[15:0];
    end
  end

  // Stage J: scale by 15625 (the odd part of 10^6).
  logic        j_vld_q;
  logic [62:0] j_y_q;
  side_j_t     j_side_q;

  always_ff @(posedge clk_i) begin
    if (i_vld_q) begin
      j_y_q    <= 63'(i_esrh_q) * 63'(ahum_pkg::ES_DIV);
      j_side_q <= i_side_q;
    end
  end

  // Stage K: add the rounding term and detect saturation ahead of the divider.
  // The full numerator is this sum times 64 and wraps at 64 bits, so the sum
  // wraps at 58 bits.
  logic        k_vld_q;
  logic [57:0] nd, lim;
  logic        k_sat;
  logic [51:0] k_dvd_q;
  logic [32:0] k_div_q;
  side_k_t     k_side_q;

  always_comb begin
    nd    = j_y_q[57:0] + {26'd0, j_side_q.e_den, 1'b0};
    lim   = 58'(j_side_q.e_den) << 21;
    k_sat = (nd >= lim);
  end

  always_ff @(posedge clk_i) begin
    if (j_vld_q) begin
      k_dvd_q      <= k_sat ? '0 : nd[51:0];
      k_div_q      <= {j_side_q.e_den, 2'b00};
      k_side_q.pa  <= j_side_q.pa;
      k_side_q.ice <= j_side_q.ice;
      k_side_q.sat <= k_sat;
    end
  end

  // Absolute humidity in mg/m^3.
  logic               q3_vld;
  logic [DIV3_QW-1:0] ah;
  side_k_t            q3_side;

  ahum_div_pipe #(
    .DW (52),
    .VW (33),
    .QW (DIV3_QW),
    .SW ($bits(side_k_t))
  ) u_div_ah (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (k_vld_q),
    .dividend_i (k_dvd_q),
    .divisor_i  (k_div_q),
    .side_i     (k_side_q),
    .vld_o      (q3_vld),
    .quot_o     (ah),
    .side_o     (q3_side)
  );

  // Output register: one strobe per transaction.
  logic                done_q;
  ahum_pkg::ahum_out_t result_q;

  always_ff @(posedge clk_i) begin
    if (q3_vld) begin
      result_q.saturation_pressure_pa  <= q3_side.pa;
      result_q.absolute_humidity_mg_m3 <= q3_side.sat ? ahum_pkg::AH_MAX : ah;
      result_q.over_ice                <= q3_side.ice;
    end
  end

  // Valid bits of the local stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      g_vld_q  <= 1'b0;
      h_vld_q  <= 1'b0;
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      i_vld_q  <= 1'b0;
      j_vld_q  <= 1'b0;
      k_vld_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      a_vld_q  <= start && !busy;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
      d_vld_q  <= q1_vld;
      g_vld_q  <= x_vld;
      h_vld_q  <= g_vld_q;
      r1_vld_q <= h_vld_q;
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
      i_vld_q  <= q2_vld;
      j_vld_q  <= i_vld_q;
      k_vld_q  <= j_vld_q;
      done_q   <= q3_vld;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  // Checks on the pipeline timing and on the results.
  `AHUM_ASSERT_IMP(a_done_has_source, clk_i, rst_ni, done_o, $past(start && !busy, LATENCY))
  `AHUM_ASSERT_IMP(a_ice_follows_sign, clk_i, rst_ni, done_o, result_o.over_ice == $past(data_i.temperature_centi_c[14], LATENCY))
  `AHUM_ASSERT_IMP(a_ice_pressure_low, clk_i, rst_ni, done_o && result_o.over_ice, result_o.saturation_pressure_pa <= 16'd612)
  `AHUM_ASSERT_NXT(a_rh_clamped, clk_i, rst_ni, start && !busy, a_vld_q && (a_rh_q <= ahum_pkg::RH_MAX))

endmodule

### tb/tb_top.sv
// Self-checking testbench for absolute_humidity_from_temp_rh_core.
// Depends on ahum_pkg and the core; predicts each result with a fixed-point model.
`timescale 1ns / 100ps

// Scoreboard: holds predicted results in order and checks each completed transaction.
class ahum_scoreboard;
  ahum_pkg::ahum_out_t pending_q[$];
  longint unsigned     exp_rom[];
  int                  mismatch_cnt;
  int                  table_bits;

  function new(int bits);
    longint unsigned ratio;
    table_bits   = bits;
    mismatch_cnt = 0;
    exp_rom      = new[(1 << bits) + 1];
    ratio        = 64'd10 << 30;
    for (int k = 0; k < bits; k++) ratio = int_sqrt(ratio << 30);
    exp_rom[0] = 64'd1 << 30;
    for (int k = 1; k < exp_rom.size(); k++)
      exp_rom[k] = (exp_rom[k-1] * ratio + (64'd1 << 29)) >> 30;
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Work out the result of one sample and queue it.
  function void note_sample(ahum_pkg::ahum_in_t s);
    ahum_pkg::ahum_out_t r;
    int              t, ip, idx, rem, sh;
    longint unsigned rh, k2m, k3c, tabs, num, den, xabs, xoff, frac, p, m, es8, pa, ah, p10;
    bit              ice;
    t  = int'(s.temperature_centi_c);
    rh = s.relative_humidity_centi_pct;
    if (t < ahum_pkg::T_MIN) t = ahum_pkg::T_MIN;
    if (t > ahum_pkg::T_MAX) t = ahum_pkg::T_MAX;
    if (rh > ahum_pkg::RH_MAX) rh = ahum_pkg::RH_MAX;
    ice  = t < 0;
    k2m  = ice ? ahum_pkg::K2_ICE : ahum_pkg::K2_WATER;
    k3c  = ice ? ahum_pkg::K3_ICE : ahum_pkg::K3_WATER;
    tabs = ice ? -t : t;
    // Exponent in Q16, offset by four so it stays positive.
    num  = k2m * tabs * 65536;
    den  = 1000 * longint'(int'(k3c) + t);
    xabs = (num + den / 2) / den;
    xoff = ice ? (64'd4 << 16) - xabs : (64'd4 << 16) + xabs;
    ip   = int'(xoff >> 16);
    if (ip > 8) ip = 8;
    frac = xoff & 64'hFFFF;
    // Table lookup with linear interpolation.
    sh  = 16 - table_bits;
    idx = int'(frac >> sh);
    rem = int'(frac & ((64'd1 << sh) - 1));
    p   = exp_rom[idx] + (((exp_rom[idx+1] - exp_rom[idx]) * rem + ((64'd1 << sh) >> 1)) >> sh);
    p10 = 1;
    for (int i = 0; i < ((ip >= 4) ? ip - 4 : 4 - ip); i++) p10 *= 10;
    m = 61121 * p;
    if (ip >= 4) begin
      m  *= p10;
      den = 64'd100 << 22;
    end else begin
      den = (64'd100 << 22) * p10;
    end
    es8 = (m + den / 2) / den;
    pa  = (es8 + 128) >> 8;
    if (pa > ahum_pkg::PA_MAX) pa = ahum_pkg::PA_MAX;
    num = es8 * rh * 1000000;
    den = 46151 * longint'(t + 27315) * 256;
    ah  = (num + den / 2) / den;
    if (ah > ahum_pkg::AH_MAX) ah = ahum_pkg::AH_MAX;
    r.saturation_pressure_pa  = pa[15:0];
    r.absolute_humidity_mg_m3 = ah[18:0];
    r.over_ice                = ice;
    pending_q.push_back(r);
  endfunction

  // Compare one completed transaction with the oldest prediction.
  function void check_result(ahum_pkg::ahum_out_t got);
    ahum_pkg::ahum_out_t want;
    if (pending_q.size() == 0) begin
      report(got, got, 1'b1);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) report(want, got, 1'b0);
  endfunction

  function void report(ahum_pkg::ahum_out_t want, ahum_pkg::ahum_out_t got, bit unexpected);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      if (unexpected)
        $display("unexpected result pa=%0d ah=%0d ice=%0d", got.saturation_pressure_pa,
                 got.absolute_humidity_mg_m3, got.over_ice);
      else
        $display("mismatch: expected pa=%0d ah=%0d ice=%0d, got pa=%0d ah=%0d ice=%0d",
                 want.saturation_pressure_pa, want.absolute_humidity_mg_m3, want.over_ice,
                 got.saturation_pressure_pa, got.absolute_humidity_mg_m3, got.over_ice);
    end
  endfunction
endclass

module tb_top;

  localparam int LATENCY     = 54;
  localparam int RANDOM_CNT  = 1700;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  ahum_pkg::ahum_in_t  data_i;
  logic                done_o;
  ahum_pkg::ahum_out_t result_o;

  ahum_scoreboard humidity_sb;
  int unsigned    cycle_cnt = 0;

  absolute_humidity_from_temp_rh_core u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .data_i   (data_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Clock, 8 ns period.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Check every completed transaction and note every accepted one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) humidity_sb.note_sample(data_i);
      if (done_o) humidity_sb.check_result(result_o);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one sample, after a random gap if allowed, and hold it until it is accepted.
  task automatic send_sample(logic signed [14:0] t, logic [13:0] rh, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start                              <= 1'b1;
    data_i.temperature_centi_c         <= t;
    data_i.relative_humidity_centi_pct <= rh;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    logic signed [14:0] t;
    logic [13:0]        rh;
    bit                 bursty;
    humidity_sb = new(6);
    rst_ni      = 1'b0;
    start       = 1'b0;
    data_i      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range limits, zero degrees, clamping of both fields, full saturation.
    send_sample(15'sd0, 14'd5000, 1'b0);
    send_sample(-15'sd1, 14'd5000, 1'b0);
    send_sample(15'sd1, 14'd10000, 1'b0);
    send_sample(-15'sd4000, 14'd0, 1'b0);
    send_sample(-15'sd4000, 14'd10000, 1'b0);
    send_sample(15'sd8500, 14'd10000, 1'b0);
    send_sample(15'sd8500, 14'd0, 1'b0);
    send_sample(15'sd16383, 14'd16383, 1'b0);
    send_sample(-15'sd16384, 14'd16383, 1'b0);
    send_sample(-15'sd4001, 14'd10001, 1'b0);
    send_sample(15'sd8501, 14'd9999, 1'b0);
    send_sample(15'sd2500, 14'd4000, 1'b1);
    send_sample(15'sd10000, 14'd1, 1'b1);
    send_sample(-15'sd1000, 14'd8000, 1'b1);
    send_sample(15'sd7000, 14'd12000, 1'b1);

    // Random samples, mostly in range, some out of range; bursts without gaps too.
    for (int n = 0; n < RANDOM_CNT; n++) begin
      if (n % 100 == 0) bursty = $urandom_range(0, 2) == 0;
      case ($urandom_range(0, 9))
        0:       t = 15'($urandom());
        1:       t = $urandom_range(0, 1) ? 15'sd0 : -15'sd1;
        default: t = $signed(15'($urandom_range(0, 12500))) - 15'sd4000;
      endcase
      rh = ($urandom_range(0, 9) == 0) ? 14'($urandom()) : 14'($urandom_range(0, 10000));
      send_sample(t, rh, !bursty);
    end
    start <= 1'b0;

    // Drain outstanding results, then settle.
    while (humidity_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    if (humidity_sb.mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+hdl
hdl/ahum_pkg.sv
hdl/ahum_div_pipe.sv
hdl/ahum_exp10.sv
hdl/absolute_humidity_from_temp_rh_core.sv
tb/tb_top.sv
